/* hw/rtl/swot_pkg.sv */
// ----------------------------------------------------------------------------
// swot_pkg
// Shared constants and types of the sliding window opening / top-hat block.
// ----------------------------------------------------------------------------
package swot_pkg;

   localparam int MAX_WINDOW  = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int IDX_BITS    = $clog2(MAX_WINDOW);
   localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [CNT_BITS-1:0]    count_type;
   typedef logic [IDX_BITS-1:0]    index_type;

   typedef struct packed {
      logic       last_result;
      sample_type residual;
      sample_type opened_value;
   } rsp_word_type;

   typedef enum logic {
      ST_RUN,
      ST_FLUSH
   } state_type;

   // 0 acts as 1, anything above the longest window acts as the longest window
   function automatic count_type clamp_window(input count_type w);
      count_type r;
      if (w == count_type'(0)) begin
         r = count_type'(1);
      end else if (w > count_type'(MAX_WINDOW)) begin
         r = count_type'(MAX_WINDOW);
      end else begin
         r = w;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/swot_cell.sv */
// ----------------------------------------------------------------------------
// swot_cell
// One cell of the window row: a delayed sample, the running minimum of the
// samples up to this depth and the running maximum of the erosions up to it.
// ----------------------------------------------------------------------------
module swot_cell (
   input  logic                 clock,
   input  logic                 shift_sample,
   input  logic                 shift_erosion,
   input  swot_pkg::sample_type prev_sample,
   input  swot_pkg::sample_type prev_min,
   input  swot_pkg::sample_type prev_max,
   input  swot_pkg::sample_type new_sample,
   input  swot_pkg::sample_type new_erosion,
   output swot_pkg::sample_type sample,
   output swot_pkg::sample_type run_min,
   output swot_pkg::sample_type run_max
);
   import swot_pkg::*;

   sample_type sample_ff, sample_in;
   sample_type min_ff, min_in;
   sample_type max_ff, max_in;

   always_comb begin
      sample_in = sample_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      if (shift_sample) begin
         sample_in = prev_sample;
         min_in    = (prev_min < new_sample) ? prev_min : new_sample;
      end
      if (shift_erosion) begin
         max_in = (prev_max > new_erosion) ? prev_max : new_erosion;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
   end

   assign sample  = sample_ff;
   assign run_min = min_ff;
   assign run_max = max_ff;

endmodule

/* hw/rtl/swot_out_buf.sv */
// ----------------------------------------------------------------------------
// swot_out_buf
// Two-word result buffer between the cell row and the result channel.
// ----------------------------------------------------------------------------
module swot_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  swot_pkg::rsp_word_type push_word,
   output logic                   full,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output swot_pkg::rsp_word_type rsp_word
);
   import swot_pkg::*;

   rsp_word_type data_ff[2];
   rsp_word_type data_in[2];
   logic [1:0]   count_ff, count_in;
   logic         pop;
   logic         wr_idx;

   assign pop = rsp_tvalid && rsp_tready;

   always_comb begin
      data_in[0] = data_ff[0];
      data_in[1] = data_ff[1];
      count_in   = count_ff;
      wr_idx     = 1'b0;
      if (pop) begin
         data_in[0] = data_ff[1];
      end
      if (push) begin
         wr_idx          = (count_ff == 2'd1) && !pop;
         data_in[wr_idx] = push_word;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff[0] <= data_in[0];
      data_ff[1] <= data_in[1];
   end

   assign full       = (count_ff == 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_word   = data_ff[0];

`ifndef SYNTHESIS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("result buffer written while full");
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");
   a_head_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && count_ff == 2'd2) |=> $stable(rsp_word))
      else $error("stalled result word changed");
`endif

endmodule

/* hw/rtl/sliding_window_opening_tophat.sv */
// ----------------------------------------------------------------------------
// sliding_window_opening_tophat
// 1-D grayscale opening (sliding minimum then sliding maximum) with top-hat
// residual, built on a row of window cells.
//
// channel | dir | handshake                  | word
// req     | in  | req_tvalid / req_tready    | tdata sample, tlast end of sequence
// rsp     | out | rsp_tvalid / rsp_tready    | tdata residual, opened; tlast last
// csr     | in  | csr_valid / csr_ready      | window size
//
// one sample a cycle while a sequence runs and the result buffer is not full;
// each sample's result lags k-1 samples; an end-of-sequence word starts a flush
// of k-1 words (n for a sequence of n < k) during which no sample is taken, as
// every flush word goes through the one push port of the result buffer
// reset is synchronous: counters and result buffer count clear, window size is 1
// a stalled result channel holds off input once two words are waiting
// ----------------------------------------------------------------------------
module sliding_window_opening_tophat (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // sample
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // residual, opened_value
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data
);
   import swot_pkg::*;

   sample_type cell_sample[MAX_WINDOW];
   sample_type cell_min[MAX_WINDOW];
   sample_type cell_max[MAX_WINDOW];

   state_type  state_ff, state_in;
   count_type  window_ff, window_in;
   count_type  k_ff, k_in;
   count_type  sseen_ff, sseen_in;
   count_type  ecnt_ff, ecnt_in;
   index_type  off_ff, off_in;
   logic       short_ff, short_in;

   logic         req_accept;
   logic         buf_full;
   logic         push;
   rsp_word_type push_word;
   rsp_word_type rsp_word;

   sample_type x;
   count_type  k_cur;
   count_type  sseen_inc;
   count_type  ecnt_inc;
   count_type  cnt;
   logic       emit;
   index_type  min_idx;
   index_type  max_idx;
   index_type  hi;
   sample_type erosion;
   sample_type opened;
   sample_type delayed;

   assign x          = req_tdata;
   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_RUN) && !buf_full;
   assign req_accept = req_tvalid && req_tready;

   // per-word datapath
   always_comb begin
      k_cur     = (sseen_ff == count_type'(0)) ? clamp_window(window_ff) : k_ff;
      sseen_inc = (sseen_ff == count_type'(MAX_WINDOW)) ? sseen_ff
                                                         : sseen_ff + count_type'(1);
      ecnt_inc  = (ecnt_ff == count_type'(MAX_WINDOW)) ? ecnt_ff
                                                        : ecnt_ff + count_type'(1);
      emit      = (sseen_inc >= k_cur);
      cnt       = (ecnt_inc < k_cur) ? ecnt_inc : k_cur;
      min_idx   = index_type'(k_cur - count_type'(2));
      max_idx   = index_type'(cnt - count_type'(2));
      hi        = ({1'b0, off_ff} < (ecnt_ff - count_type'(1)))
                  ? off_ff : index_type'(ecnt_ff - count_type'(1));

      if (k_cur == count_type'(1)) begin
         erosion = x;
      end else begin
         erosion = (cell_min[min_idx] < x) ? cell_min[min_idx] : x;
      end

      if (state_ff == ST_FLUSH) begin
         opened  = short_ff ? sample_type'(0) : cell_max[hi];
         delayed = cell_sample[off_ff];
      end else begin
         if (cnt == count_type'(1)) begin
            opened = erosion;
         end else begin
            opened = (cell_max[max_idx] > erosion) ? cell_max[max_idx] : erosion;
         end
         delayed = (k_cur == count_type'(1)) ? x : cell_sample[min_idx];
      end

      push_word.opened_value = opened;
      push_word.residual     = delayed - opened;
      push_word.last_result  = (state_ff == ST_FLUSH) ? (off_ff == index_type'(0))
                               : (req_tlast && k_cur == count_type'(1));
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      window_in = window_ff;
      k_in      = k_ff;
      sseen_in  = sseen_ff;
      ecnt_in   = ecnt_ff;
      off_in    = off_ff;
      short_in  = short_ff;
      push      = 1'b0;

      if (csr_valid && csr_ready) begin
         window_in = count_type'(csr_data);
      end

      case (state_ff)
         ST_RUN: begin
            if (req_accept) begin
               k_in     = k_cur;
               sseen_in = sseen_inc;
               push     = emit;
               if (emit) begin
                  ecnt_in = ecnt_inc;
               end
               if (req_tlast) begin
                  sseen_in = count_type'(0);
                  if (emit && k_cur == count_type'(1)) begin
                     ecnt_in = count_type'(0);
                  end else if (emit) begin
                     off_in   = index_type'(k_cur - count_type'(2));
                     short_in = 1'b0;
                     state_in = ST_FLUSH;
                  end else begin
                     off_in   = index_type'(sseen_inc - count_type'(1));
                     short_in = 1'b1;
                     ecnt_in  = count_type'(0);
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!buf_full) begin
               push = 1'b1;
               if (off_ff == index_type'(0)) begin
                  ecnt_in  = count_type'(0);
                  state_in = ST_RUN;
               end else begin
                  off_in = off_ff - index_type'(1);
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RUN;
         window_ff <= count_type'(1);
         k_ff      <= count_type'(1);
         sseen_ff  <= count_type'(0);
         ecnt_ff   <= count_type'(0);
         off_ff    <= index_type'(0);
         short_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         window_ff <= window_in;
         k_ff      <= k_in;
         sseen_ff  <= sseen_in;
         ecnt_ff   <= ecnt_in;
         off_ff    <= off_in;
         short_ff  <= short_in;
      end
   end

   // cell row
   for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
      if (j == 0) begin : g_head
         swot_cell u_cell (
            .clock         (clock),
            .shift_sample  (req_accept),
            .shift_erosion (req_accept && emit),
            .prev_sample   (x),
            .prev_min      (x),
            .prev_max      (erosion),
            .new_sample    (x),
            .new_erosion   (erosion),
            .sample        (cell_sample[j]),
            .run_min       (cell_min[j]),
            .run_max       (cell_max[j])
         );
      end else begin : g_body
         swot_cell u_cell (
            .clock         (clock),
            .shift_sample  (req_accept),
            .shift_erosion (req_accept && emit),
            .prev_sample   (cell_sample[j-1]),
            .prev_min      (cell_min[j-1]),
            .prev_max      (cell_max[j-1]),
            .new_sample    (x),
            .new_erosion   (erosion),
            .sample        (cell_sample[j]),
            .run_min       (cell_min[j]),
            .run_max       (cell_max[j])
         );
      end
   end

   swot_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .full       (buf_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = {rsp_word.residual, rsp_word.opened_value};
   assign rsp_tlast = rsp_word.last_result;

`ifndef SYNTHESIS
   a_flush_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> !req_tready)
      else $error("sample taken during flush");
   a_window_range : assert property (@(posedge clock) disable iff (reset)
      (k_ff != count_type'(0)) && (k_ff <= count_type'(MAX_WINDOW)))
      else $error("latched window out of range");
   a_flush_offset : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> ({1'b0, off_ff} < k_ff))
      else $error("flush offset beyond window");
   a_flush_ends : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && !buf_full && off_ff == index_type'(0))
      |=> (state_ff == ST_RUN && ecnt_ff == count_type'(0)))
      else $error("flush did not return to run");
`endif

endmodule

/* sim/tb_sliding_window_opening_tophat.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_opening_tophat
// Self-checking regression for the 1-D grayscale opening / top-hat block.
// Each accepted sample is run through a behavioural opening model. The model
// queues the words the block should return, and a checker compares every
// returned word field by field. Directed sequences cover the window limits,
// short sequences and a window write in mid-sequence, then one long receiver
// hold-off. Random sequences with bursty input and a stalling receiver follow.
// ----------------------------------------------------------------------------
module tb_sliding_window_opening_tophat;
   import swot_pkg::*;

   localparam int RANDOM_ITEMS = 350;
   localparam int SETTLE       = 2 * MAX_WINDOW + 8;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RING_SAMPLE  = 0;
   localparam int RING_EROSION = 1;

   typedef enum {RX_ALWAYS, RX_PATTERN} rx_mode_type;
   typedef enum {FILL_FULL, FILL_NARROW, FILL_EXTREME, FILL_RAMP} fill_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [5:0]  csr_data;

   // opening model state
   sample_type   ring_mem [2][MAX_WINDOW];
   int unsigned  ring_wp [2] = '{0, 0};
   int unsigned  seen_samples = 0;
   int unsigned  seen_erosions = 0;
   int unsigned  seq_window = 1;
   logic [5:0]   window_reg = 6'd1;
   rsp_word_type opening_q [$];

   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  burst_left = 0;
   int unsigned  pending_gap = 0;
   bit           offering = 1'b0;
   bit           burst_gaps_on = 1'b1;
   int unsigned  hold_cycles = 0;
   bit           holding = 1'b0;
   rx_mode_type  rx_mode = RX_PATTERN;

   sliding_window_opening_tophat uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sliding_window_opening_tophat regression: fail");
         $finish;
      end
   end

   function automatic int unsigned window_in_use(input logic [5:0] w);
      int unsigned r;
      r = w;
      if (r < 1) r = 1;
      if (r > MAX_WINDOW) r = MAX_WINDOW;
      return r;
   endfunction

   function automatic sample_type ring_back(input int r, input int unsigned back);
      return ring_mem[r][(ring_wp[r] + 2 * MAX_WINDOW - 1 - (back % MAX_WINDOW)) % MAX_WINDOW];
   endfunction

   function automatic sample_type erosion_peak(input int unsigned hi);
      sample_type m;
      sample_type v;
      m = '0;
      for (int unsigned d = 0; d <= hi && d < MAX_WINDOW; d++) begin
         v = ring_back(RING_EROSION, d);
         if (v > m) m = v;
      end
      return m;
   endfunction

   function automatic void push_result(input sample_type opened, input sample_type delayed,
                                       input logic last);
      rsp_word_type w;
      w.opened_value = opened;
      w.residual     = delayed - opened;
      w.last_result  = last;
      opening_q = {opening_q, w};
   endfunction

   task automatic predict_opening(input sample_type s, input logic eos);
      int unsigned k;
      int unsigned hi;
      int unsigned cnt;
      sample_type  e;
      sample_type  v;
      if (seen_samples == 0) seq_window = window_in_use(window_reg);
      k = seq_window;
      ring_mem[RING_SAMPLE][ring_wp[RING_SAMPLE]] = s;
      ring_wp[RING_SAMPLE] = (ring_wp[RING_SAMPLE] + 1) % MAX_WINDOW;
      if (seen_samples < MAX_WINDOW) seen_samples++;
      if (seen_samples >= k) begin
         e = ring_back(RING_SAMPLE, 0);
         for (int unsigned d = 1; d < k; d++) begin
            v = ring_back(RING_SAMPLE, d);
            if (v < e) e = v;
         end
         ring_mem[RING_EROSION][ring_wp[RING_EROSION]] = e;
         ring_wp[RING_EROSION] = (ring_wp[RING_EROSION] + 1) % MAX_WINDOW;
         if (seen_erosions < MAX_WINDOW) seen_erosions++;
         cnt = (seen_erosions < k) ? seen_erosions : k;
         push_result(erosion_peak(cnt - 1), ring_back(RING_SAMPLE, k - 1), eos && k == 1);
         if (eos) begin
            for (int unsigned f = 1; f < k; f++) begin
               hi = k - 1 - f;
               if (hi > seen_erosions - 1) hi = seen_erosions - 1;
               push_result(erosion_peak(hi), ring_back(RING_SAMPLE, k - 1 - f), f == k - 1);
            end
         end
      end else if (eos) begin
         for (int unsigned f = 0; f < seen_samples; f++) begin
            push_result('0, ring_back(RING_SAMPLE, seen_samples - 1 - f),
                        f == seen_samples - 1);
         end
      end
      if (eos) begin
         seen_samples  = 0;
         seen_erosions = 0;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (opening_q.size() == 0) begin
            $display("%0t: unexpected word: opened %h residual %h last %b", $time,
                     rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
            mismatch_count++;
         end else begin
            w = opening_q.pop_front();
            if (w.opened_value !== rsp_tdata[15:0] || w.residual !== rsp_tdata[31:16] ||
                w.last_result !== rsp_tlast) begin
               $display("%0t: expected opened %h res %h last %b, actual opened %h res %h last %b",
                        $time, w.opened_value, w.residual, w.last_result,
                        rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // receiver stall pattern and long hold-off
   initial begin : rsp_stall
      int unsigned on_len;
      int unsigned off_len;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            holding = 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            holding     = 1'b0;
         end else if (rx_mode == RX_ALWAYS) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            on_len  = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            off_len = $urandom_range(0, 8);
            rsp_tready <= 1'b1;
            repeat (on_len) @(posedge clock);
            if (off_len != 0) begin
               rsp_tready <= 1'b0;
               repeat (off_len) @(posedge clock);
            end
         end
      end
   end

   task automatic send_sample(input sample_type s, input logic eos);
      if (pending_gap != 0) begin
         repeat (pending_gap) @(posedge clock);
         pending_gap = 0;
      end
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      predict_opening(s, eos);
      burst_left--;
      if (burst_left == 0 && burst_gaps_on) begin
         req_tvalid <= 1'b0;
         offering    = 1'b0;
         pending_gap = $urandom_range(1, 8);
      end else begin
         offering = 1'b1;
      end
   endtask

   task automatic wait_drain();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      burst_left = 0;
      do @(posedge clock); while (opening_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
      pending_gap = 0;
   endtask

   task automatic write_window(input logic [5:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_reg = value;
   endtask

   task automatic test_reset_window();
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h1234, 1'b1);
   endtask

   task automatic test_window_extremes();
      wait_drain();
      write_window(6'd0);
      send_sample(16'hFFFF, 1'b1);
      wait_drain();
      // above the longest window, and shorter than it
      write_window(6'd63);
      send_sample(16'hAAAA, 1'b0);
      send_sample(16'h5555, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0000, 1'b1);
   endtask

   task automatic test_normal_end();
      wait_drain();
      write_window(6'd4);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0001, 1'b1);
   endtask

   task automatic test_mid_sequence_write();
      wait_drain();
      write_window(6'd3);
      send_sample(16'd10, 1'b0);
      send_sample(16'd20, 1'b0);
      send_sample(16'd30, 1'b0);
      // new window only applies from the next sequence
      wait_drain();
      write_window(6'd7);
      send_sample(16'd5, 1'b0);
      send_sample(16'd40, 1'b1);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h0100, 1'b1);
   endtask

   task automatic test_backpressure();
      wait_drain();
      write_window(6'd6);
      burst_gaps_on = 1'b0;
      hold_cycles   = 300;
      while (!holding) @(posedge clock);
      for (int i = 0; i < 40; i++) begin
         send_sample(sample_type'($urandom_range(0, 65535)), i == 39);
      end
      wait_drain();
      burst_gaps_on = 1'b1;
   endtask

   function automatic logic [5:0] pick_window();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return 6'd0;
      if (r == 1) return 6'($urandom_range(33, 63));
      if (r == 2) return 6'd32;
      if (r <= 5) return 6'($urandom_range(9, 31));
      return 6'($urandom_range(1, 8));
   endfunction

   task automatic test_random_sequences();
      int unsigned sent;
      int unsigned k;
      int unsigned len;
      int unsigned r;
      fill_type    fill;
      sample_type  base;
      sample_type  s;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            wait_drain();
            write_window(pick_window());
         end
         rx_mode = ($urandom_range(0, 3) == 0) ? RX_ALWAYS : RX_PATTERN;
         k = window_in_use(window_reg);
         r = $urandom_range(0, 19);
         if (r < 3) begin
            len = (k > 1) ? $urandom_range(1, k - 1) : 1;
         end else if (r == 3) begin
            len = $urandom_range(33, 70);
         end else begin
            len = k + $urandom_range(0, (k <= 8) ? 12 : 4);
         end
         fill = fill_type'($urandom_range(0, 3));
         base = sample_type'($urandom_range(0, 65535));
         for (int unsigned i = 0; i < len; i++) begin
            case (fill)
               FILL_FULL:    s = sample_type'($urandom_range(0, 65535));
               FILL_NARROW:  s = base + sample_type'($urandom_range(0, 15));
               FILL_EXTREME: s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               default:      s = base + sample_type'(i * 97);
            endcase
            send_sample(s, i == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_window();
      test_window_extremes();
      test_normal_end();
      test_mid_sequence_write();
      test_backpressure();
      test_random_sequences();
      wait_drain();
      if (mismatch_count == 0) begin
         $display("sliding_window_opening_tophat regression: pass");
      end else begin
         $display("sliding_window_opening_tophat regression: fail");
      end
      $finish;
   end

endmodule
